// ===== sv/ttcd_pkg.sv =====
// shared types, codes and character helpers for the ternary trie command decoder
package ttcd_pkg;

  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned CODE_IN_W  = 5;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned SYM_W      = 2;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_DECODE = 1'b1;

  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TAB     = 8'h09;
  localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;

  localparam logic [SYM_W-1:0] SYM_SPACE   = 2'd0;
  localparam logic [SYM_W-1:0] SYM_TAB     = 2'd1;
  localparam logic [SYM_W-1:0] SYM_NEWLINE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_FOUND        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_UNRECOGNIZED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_END          = 3'd2;
  localparam logic [STATUS_W-1:0] ST_INSERTED     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_AMBIGUOUS    = 3'd4;
  localparam logic [STATUS_W-1:0] ST_FULL         = 3'd5;

  // classified request as it travels from front to back
  typedef struct packed {
    logic                 op;
    logic                 sym_ok;
    logic [SYM_W-1:0]     sym;
    logic                 key_last;
    logic [CODE_IN_W-1:0] code;
    logic                 at_end;
  } cmd_t;

  typedef struct packed {
    logic             ok;
    logic [SYM_W-1:0] sym;
  } sym_t;

  function automatic sym_t sym_of(input logic [CHAR_W-1:0] ch);
    sym_t s;
    s.ok  = 1'b1;
    s.sym = SYM_SPACE;
    case (ch)
      CH_SPACE:   s.sym = SYM_SPACE;
      CH_TAB:     s.sym = SYM_TAB;
      CH_NEWLINE: s.sym = SYM_NEWLINE;
      default:    s.ok  = 1'b0;
    endcase
    return s;
  endfunction

endpackage

// ===== sv/ttcd_front.sv =====
// front end: classifies incoming characters and queues the requests that do work
module ttcd_front (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic                               in_op,
  input  logic [ttcd_pkg::CHAR_W-1:0]        in_char_in,
  input  logic                               in_key_last,
  input  logic [ttcd_pkg::CODE_IN_W-1:0]     in_cmd_code,
  input  logic                               in_at_end,
  output logic                               q_valid,
  output ttcd_pkg::cmd_t                     q_cmd,
  input  logic                               q_pop
);

  localparam int unsigned PTR_W = $clog2(ttcd_pkg::QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(ttcd_pkg::QUEUE_DEPTH + 1);

  ttcd_pkg::cmd_t   q_mem_r [ttcd_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  ttcd_pkg::sym_t   sym;
  ttcd_pkg::cmd_t   cmd;
  logic             keep;
  logic             push;
  logic             pop;

  always_comb begin
    sym          = ttcd_pkg::sym_of(in_char_in);
    cmd.op       = in_op;
    cmd.sym_ok   = sym.ok;
    cmd.sym      = sym.sym;
    cmd.key_last = in_key_last;
    cmd.code     = in_cmd_code;
    cmd.at_end   = in_at_end;
    // skipped characters that neither end a key nor end the stream do nothing
    if (in_op == ttcd_pkg::OP_DECODE) begin
      keep = in_at_end | sym.ok;
    end else begin
      keep = in_key_last | sym.ok;
    end
  end

  assign busy    = (cnt_r == CNT_W'(ttcd_pkg::QUEUE_DEPTH));
  assign push    = start & ~busy & keep;
  assign q_valid = (cnt_r != '0);
  assign pop     = q_pop & q_valid;
  assign q_cmd   = q_mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + PTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= cmd;
    end
  end

endmodule

// ===== sv/ttcd_back.sv =====
// back end: node table, cursors and the insert / decode sequencer
module ttcd_back #(
  parameter int unsigned NODE_COUNT = 64,
  parameter int unsigned CODE_BITS  = 5
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               q_valid,
  input  ttcd_pkg::cmd_t                     q_cmd,
  output logic                               q_pop,
  output logic                               out_strobe,
  output logic [ttcd_pkg::STATUS_W-1:0]      out_status,
  output logic [ttcd_pkg::CODE_IN_W-1:0]     out_cmd_out
);

  localparam int unsigned AW = $clog2(NODE_COUNT);

  typedef struct packed {
    logic [2:0][AW-1:0]   links;
    logic [CODE_BITS-1:0] code;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_STEP  = 4'b0010,
    S_CHK   = 4'b0100,
    S_ALLOC = 4'b1000
  } state_t;

  state_t                  state_r, state_nxt;
  ttcd_pkg::cmd_t          cmd_r, cmd_nxt;
  logic [AW-1:0]           ins_cur_r, ins_cur_nxt;
  logic                    ins_fail_r, ins_fail_nxt;
  logic [AW-1:0]           dec_cur_r, dec_cur_nxt;
  logic [AW:0]             free_r, free_nxt;
  logic [2:0][AW-1:0]      root_links_r, root_links_nxt;

  entry_t                  mem [NODE_COUNT];
  entry_t                  rd_data_r;
  logic                    rd_root_r;
  logic                    mem_re;
  logic [AW-1:0]           mem_ra;
  logic                    mem_we;
  logic [AW-1:0]           mem_wa;
  entry_t                  mem_wd;

  logic                                  emit;
  logic [ttcd_pkg::STATUS_W-1:0]         emit_status;
  logic [ttcd_pkg::CODE_IN_W-1:0]        emit_code;
  logic                                  out_strobe_r;
  logic [ttcd_pkg::STATUS_W-1:0]         out_status_r;
  logic [ttcd_pkg::CODE_IN_W-1:0]        out_cmd_r;

  entry_t                  ent;
  logic [AW-1:0]           nxt_link;
  logic [2:0][AW-1:0]      links_upd;
  logic                    ambiguous;
  logic                    has_room;

  // root lives in flops, so its cleared state holds from reset
  always_comb begin
    if (rd_root_r) begin
      ent.links = root_links_r;
      ent.code  = '0;
    end else begin
      ent = rd_data_r;
    end
    case (cmd_r.sym)
      ttcd_pkg::SYM_SPACE:   nxt_link = ent.links[0];
      ttcd_pkg::SYM_TAB:     nxt_link = ent.links[1];
      ttcd_pkg::SYM_NEWLINE: nxt_link = ent.links[2];
      default:               nxt_link = '0;
    endcase
    links_upd = ent.links;
    case (cmd_r.sym)
      ttcd_pkg::SYM_SPACE:   links_upd[0] = free_r[AW-1:0];
      ttcd_pkg::SYM_TAB:     links_upd[1] = free_r[AW-1:0];
      ttcd_pkg::SYM_NEWLINE: links_upd[2] = free_r[AW-1:0];
      default:               links_upd    = ent.links;
    endcase
    ambiguous = (ins_cur_r == '0) || (ent.code != '0) || (ent.links[0] != '0) ||
                (ent.links[1] != '0) || (ent.links[2] != '0);
    has_room  = (free_r < (AW+1)'(NODE_COUNT));
  end

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    ins_cur_nxt    = ins_cur_r;
    ins_fail_nxt   = ins_fail_r;
    dec_cur_nxt    = dec_cur_r;
    free_nxt       = free_r;
    root_links_nxt = root_links_r;
    q_pop          = 1'b0;
    mem_re         = 1'b0;
    mem_ra         = '0;
    mem_we         = 1'b0;
    mem_wa         = '0;
    mem_wd         = '0;
    emit           = 1'b0;
    emit_status    = ttcd_pkg::ST_FOUND;
    emit_code      = '0;

    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop   = 1'b1;
          cmd_nxt = q_cmd;
          if (q_cmd.op == ttcd_pkg::OP_DECODE) begin
            if (q_cmd.at_end) begin
              emit        = 1'b1;
              emit_status = ttcd_pkg::ST_END;
              dec_cur_nxt = '0;
            end else begin
              mem_re    = 1'b1;
              mem_ra    = dec_cur_r;
              state_nxt = S_STEP;
            end
          end else if (ins_fail_r) begin
            if (q_cmd.key_last) begin
              emit         = 1'b1;
              emit_status  = ttcd_pkg::ST_FULL;
              ins_cur_nxt  = '0;
              ins_fail_nxt = 1'b0;
            end
          end else begin
            mem_re    = 1'b1;
            mem_ra    = ins_cur_r;
            state_nxt = S_STEP;
          end
        end
      end

      S_STEP: begin
        state_nxt = S_IDLE;
        if (cmd_r.op == ttcd_pkg::OP_DECODE) begin
          if (nxt_link == '0) begin
            emit        = 1'b1;
            emit_status = ttcd_pkg::ST_UNRECOGNIZED;
            dec_cur_nxt = '0;
          end else begin
            dec_cur_nxt = nxt_link;
            mem_re      = 1'b1;
            mem_ra      = nxt_link;
            state_nxt   = S_CHK;
          end
        end else if (cmd_r.sym_ok) begin
          if (nxt_link != '0) begin
            ins_cur_nxt = nxt_link;
            if (cmd_r.key_last) begin
              mem_re    = 1'b1;
              mem_ra    = nxt_link;
              state_nxt = S_CHK;
            end
          end else if (has_room) begin
            // hook the new node under its parent, then clear it next cycle
            if (rd_root_r) begin
              root_links_nxt = links_upd;
            end else begin
              mem_we       = 1'b1;
              mem_wa       = ins_cur_r;
              mem_wd.links = links_upd;
              mem_wd.code  = ent.code;
            end
            state_nxt = S_ALLOC;
          end else if (cmd_r.key_last) begin
            emit         = 1'b1;
            emit_status  = ttcd_pkg::ST_FULL;
            ins_cur_nxt  = '0;
            ins_fail_nxt = 1'b0;
          end else begin
            ins_fail_nxt = 1'b1;
          end
        end else begin
          // skipped character carrying key end: check node reached so far
          emit        = 1'b1;
          ins_cur_nxt = '0;
          if (ambiguous) begin
            emit_status = ttcd_pkg::ST_AMBIGUOUS;
          end else begin
            emit_status  = ttcd_pkg::ST_INSERTED;
            mem_we       = 1'b1;
            mem_wa       = ins_cur_r;
            mem_wd.links = ent.links;
            mem_wd.code  = CODE_BITS'(cmd_r.code);
          end
        end
      end

      S_CHK: begin
        state_nxt = S_IDLE;
        if (cmd_r.op == ttcd_pkg::OP_DECODE) begin
          if (ent.code != '0) begin
            emit        = 1'b1;
            emit_status = ttcd_pkg::ST_FOUND;
            emit_code   = ttcd_pkg::CODE_IN_W'(ent.code);
            dec_cur_nxt = '0;
          end
        end else begin
          emit        = 1'b1;
          ins_cur_nxt = '0;
          if (ambiguous) begin
            emit_status = ttcd_pkg::ST_AMBIGUOUS;
          end else begin
            emit_status  = ttcd_pkg::ST_INSERTED;
            mem_we       = 1'b1;
            mem_wa       = ins_cur_r;
            mem_wd.links = ent.links;
            mem_wd.code  = CODE_BITS'(cmd_r.code);
          end
        end
      end

      S_ALLOC: begin
        // a fresh leaf can take the code directly when the key ends here
        state_nxt    = S_IDLE;
        mem_we       = 1'b1;
        mem_wa       = free_r[AW-1:0];
        mem_wd.links = '0;
        mem_wd.code  = cmd_r.key_last ? CODE_BITS'(cmd_r.code) : '0;
        free_nxt     = free_r + (AW+1)'(1);
        if (cmd_r.key_last) begin
          emit        = 1'b1;
          emit_status = ttcd_pkg::ST_INSERTED;
          ins_cur_nxt = '0;
        end else begin
          ins_cur_nxt = free_r[AW-1:0];
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      ins_cur_r    <= '0;
      ins_fail_r   <= 1'b0;
      dec_cur_r    <= '0;
      free_r       <= (AW+1)'(1);
      root_links_r <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      ins_cur_r    <= ins_cur_nxt;
      ins_fail_r   <= ins_fail_nxt;
      dec_cur_r    <= dec_cur_nxt;
      free_r       <= free_nxt;
      root_links_r <= root_links_nxt;
      out_strobe_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    out_status_r <= emit_status;
    out_cmd_r    <= emit_code;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_ra];
      rd_root_r <= (mem_ra == '0);
    end
  end

  assign out_strobe  = out_strobe_r;
  assign out_status  = out_status_r;
  assign out_cmd_out = out_cmd_r;

  a_no_root_write: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> mem_wa != '0)
    else $error("node table write aimed at root");

  a_free_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && $past(rst_n)) |-> free_r >= $past(free_r))
    else $error("allocation count went backwards");

  a_alloc_after_step: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_ALLOC |-> $past(state_r) == S_STEP)
    else $error("allocation without a preceding child lookup");

  a_null_code: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe_r && out_status_r != ttcd_pkg::ST_FOUND) |-> out_cmd_r == '0)
    else $error("non-found result carries a command code");

endmodule

// ===== sv/ternary_trie_command_decoder.sv =====
// top level of the ternary trie command decoder: front queue plus node table back end
// timing: a request waits in the two-entry queue until the back end is idle and pops it; the
//   back end answers at once (end of input, key end after table full), after one node read,
//   or after a second node read or a node allocation; out_strobe rises the next cycle
// flow: the back end handles one request at a time; the two-entry queue takes more meanwhile
// reset: synchronous on rst_n low; cursors and queue clear, allocation count starts at 1,
//   root links clear in flops; other nodes clear only as allocated (no clearing pass)
module ternary_trie_command_decoder #(
  parameter int unsigned NODE_COUNT = 64,
  parameter int unsigned CODE_BITS  = 5
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // request channel
  input  logic                               start,
  output logic                               busy,
  input  logic                               in_op,
  input  logic [ttcd_pkg::CHAR_W-1:0]        in_char_in,
  input  logic                               in_key_last,
  input  logic [ttcd_pkg::CODE_IN_W-1:0]     in_cmd_code,
  input  logic                               in_at_end,
  // result channel, one-cycle strobe, cannot be stalled
  output logic                               out_strobe,
  output logic [ttcd_pkg::STATUS_W-1:0]      out_status,
  output logic [ttcd_pkg::CODE_IN_W-1:0]     out_cmd_out
);

  // classified request waiting at the queue head
  logic           q_valid;
  ttcd_pkg::cmd_t q_cmd;
  logic           q_pop;

  // front: symbol decode, drops requests that change nothing, two-entry queue
  ttcd_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_op       (in_op),
    .in_char_in  (in_char_in),
    .in_key_last (in_key_last),
    .in_cmd_code (in_cmd_code),
    .in_at_end   (in_at_end),
    .q_valid     (q_valid),
    .q_cmd       (q_cmd),
    .q_pop       (q_pop)
  );

  // back: walks the node table for inserts and decodes, registers the result
  ttcd_back #(
    .NODE_COUNT (NODE_COUNT),
    .CODE_BITS  (CODE_BITS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_valid     (q_valid),
    .q_cmd       (q_cmd),
    .q_pop       (q_pop),
    .out_strobe  (out_strobe),
    .out_status  (out_status),
    .out_cmd_out (out_cmd_out)
  );

endmodule
